// ----- rtl/ddf_pkg.sv -----
// Package of the decimal digit display formatter: constants, register indexes and types.
`default_nettype none

package ddf_pkg;

	// Largest digit count and the widths that follow from it
	localparam int MAX_DIGITS = 8;
	localparam int DIGIT_W    = 4;
	localparam int VALUE_W    = 32;
	localparam int CODE_W     = 8;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 1;

	// Code-B constants
	localparam logic [CODE_W-1:0] BLANK_CODE = 8'h0f;
	localparam logic [CODE_W-1:0] POINT_BIT  = 8'h80;
	localparam logic [3:0]        LAST_DEC   = 4'd9;

	// Reciprocal of ten: n / 10 == (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hcccc_cccd;
	localparam int                 RECIP_SHIFT = 35;

	// Reset values of the registers
	localparam logic [CFG_W-1:0] COUNT_RESET = 4'd8;
	localparam logic [CFG_W-1:0] POINT_RESET = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIGIT_COUNT    = 1'b0,
		REG_POINT_POSITION = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/decimal_digit_display_formatter.sv -----
// Top level of the decimal digit display formatter: divide-by-ten sequencer and output register.
//
//   channel  direction  handshake            payload
//   ------   ---------  -------------------  ----------------------------------------
//   in       sink       in_valid / in_stall  number[31:0]
//   out      source     out_valid/out_stall  digit_register[3:0], segment_code[7:0],
//                                            last_digit
//   cfg      sink       cfg_write_en         cfg_index[0:0], cfg_data[3:0]
//
// One number yields digit_count digits (0 to 8; larger settings saturate at 8), one digit per
// cycle, from the single divide-by-ten unit (a 32x32 reciprocal multiply). The next number is
// taken in the cycle that produces the last digit of the current one, so back-to-back numbers
// run at one digit write per cycle; a zero count yields no digit and the sequencer stays idle.
// A stall on the output holds the sequencer: a digit is produced only when the output
// register is empty or its contents transfer in that cycle.
// Reset (arst_n low) empties the output register, returns to idle and restores
// digit_count to 8 and point_position to 3.
`default_nettype none

module decimal_digit_display_formatter
	import ddf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [VALUE_W-1:0]   number,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [DIGIT_W-1:0]        digit_register,
	output logic [CODE_W-1:0]         segment_code,
	output logic                      last_digit,

	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [CFG_W-1:0] count_cfg_q;
	logic [CFG_W-1:0] point_cfg_q;

	// Sequencer state
	state_t               state_q;
	logic [VALUE_W-1:0]   rest_q;
	logic [DIGIT_W-1:0]   pos_q;
	logic [DIGIT_W-1:0]   count_q;

	// Output register
	logic                 out_valid_q;
	logic [DIGIT_W-1:0]   digit_reg_q;
	logic [CODE_W-1:0]    code_q;
	logic                 last_q;

	// Shared divide-by-ten unit
	logic [2*VALUE_W-1:0] product;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   rem_wide;
	logic [3:0]           rem;

	logic                 slot_free;
	logic                 step;
	logic                 at_last;
	logic                 in_xfer;
	logic [DIGIT_W-1:0]   count_sat;
	logic [CODE_W-1:0]    digit_code;
	logic [CODE_W-1:0]    next_code;

	// Divide the remaining value by ten; the remainder is the next digit
	assign product  = {{VALUE_W{1'b0}}, rest_q} * {{VALUE_W{1'b0}}, RECIP_TEN};
	assign quot     = {{RECIP_SHIFT-VALUE_W{1'b0}}, product[2*VALUE_W-1:RECIP_SHIFT]};
	assign rem_wide = rest_q - (quot << 3) - (quot << 1);
	assign rem      = rem_wide[3:0];

	// Blank a leading zero above the point; mark the point position
	always_comb begin
		digit_code = {4'b0000, rem};
		if ((pos_q > point_cfg_q) && (rem == 4'd0) && (quot == '0)) begin
			digit_code = BLANK_CODE;
		end
		next_code = digit_code;
		if (pos_q == point_cfg_q) begin
			next_code = digit_code | POINT_BIT;
		end
	end

	// Saturate the digit count at the display width
	assign count_sat = (count_cfg_q > DIGIT_W'(MAX_DIGITS)) ? DIGIT_W'(MAX_DIGITS)
	                                                       : count_cfg_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign step      = (state_q == ST_RUN) && slot_free;
	assign at_last   = (pos_q == count_q);
	assign in_stall  = !((state_q == ST_IDLE) || (step && at_last));
	assign in_xfer   = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= COUNT_RESET;
			point_cfg_q <= POINT_RESET;
		end else if (cfg_write_en) begin
			case (reg_index_t'(cfg_index))
				REG_DIGIT_COUNT:    count_cfg_q <= cfg_data;
				REG_POINT_POSITION: point_cfg_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Sequencer: load a number on transfer, then advance one digit per free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (in_xfer) begin
			state_q <= (count_sat == '0) ? ST_IDLE : ST_RUN;
		end else if (step && at_last) begin
			state_q <= ST_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rest_q  <= number;
			pos_q   <= DIGIT_W'(1);
			count_q <= count_sat;
		end else if (step) begin
			rest_q <= quot;
			pos_q  <= pos_q + DIGIT_W'(1);
		end
	end

	// Output register: fill on a step, drop once the digit has transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			digit_reg_q <= pos_q;
			code_q      <= next_code;
			last_q      <= at_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign digit_register = digit_reg_q;
	assign segment_code   = code_q;
	assign last_digit     = last_q;

`ifndef SYNTHESIS
	// A non-final digit on show means the sequencer still has digits to go
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_digit |-> state_q == ST_RUN)
		else $error("non-final digit shown while sequencer idle");

	// The digit nibble is a decimal digit or the blank code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segment_code[3:0] <= LAST_DEC) || (segment_code[3:0] == BLANK_CODE[3:0]))
		else $error("bad code-B digit");

	// While running, the position stays within the display
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (pos_q != '0) && (pos_q <= count_q)
			&& (count_q <= DIGIT_W'(MAX_DIGITS)))
		else $error("digit position out of range");
`endif

endmodule

`default_nettype wire
